// ----- design/sorted_deadline_timer_queue_assert.svh -----
// Assertion macros used by the checker file of the timer queue.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define SDTQ_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SDTQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/sdtq_pkg.sv -----
package sdtq_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 4;
    localparam int IVL_W      = 31;
    localparam int IN_DATA_W  = 40;   // id + interval, padded to bytes
    localparam int OUT_DATA_W = 8;    // fired + fired_id + status, padded

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIMER_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_CREATE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RESP = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- design/sdtq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts towards the head on a
// pop and towards the tail behind an insert point.
module sdtq_cell #(
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdtq_pkg::t_cell_ctl       i_ctl,
    input  logic [TIME_BITS-1:0]      i_new_dl,
    input  logic [sdtq_pkg::ID_W-1:0] i_new_id,
    input  logic                      i_found,
    output logic                      o_found,
    input  logic                      i_left_v,
    input  logic [TIME_BITS-1:0]      i_left_dl,
    input  logic [sdtq_pkg::ID_W-1:0] i_left_id,
    input  logic                      i_right_v,
    input  logic [TIME_BITS-1:0]      i_right_dl,
    input  logic [sdtq_pkg::ID_W-1:0] i_right_id,
    output logic                      o_v,
    output logic [TIME_BITS-1:0]      o_dl,
    output logic [sdtq_pkg::ID_W-1:0] o_id
);

    logic                      r_v;
    logic [TIME_BITS-1:0]      r_dl;
    logic [sdtq_pkg::ID_W-1:0] r_id;
    logic                      n_v;
    logic [TIME_BITS-1:0]      n_dl;
    logic [sdtq_pkg::ID_W-1:0] n_id;
    logic [TIME_BITS-1:0]      w_diff;
    logic                      w_after;

    // New deadline strictly after the held one (signed wrap difference).
    assign w_diff  = i_new_dl - r_dl;
    assign w_after = r_v && (w_diff != '0) && !w_diff[TIME_BITS-1];
    assign o_found = i_found || !w_after;

    always_comb begin
        n_v  = r_v;
        n_dl = r_dl;
        n_id = r_id;
        if (i_ctl.pop) begin
            n_v  = i_right_v;
            n_dl = i_right_dl;
            n_id = i_right_id;
        end else if (i_ctl.insert) begin
            if (i_found) begin
                n_v  = i_left_v;
                n_dl = i_left_dl;
                n_id = i_left_id;
            end else if (!w_after) begin
                n_v  = 1'b1;
                n_dl = i_new_dl;
                n_id = i_new_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_dl <= n_dl;
        r_id <= n_id;
    end

    assign o_v  = r_v;
    assign o_dl = r_dl;
    assign o_id = r_id;

endmodule

// ----- design/sorted_deadline_timer_queue.sv -----
// One-shot timer queue with entries kept sorted by deadline.
// Input channel (s_axis): tuser carries the command (tick, start, cancel,
// create); tdata carries timer id and interval in ticks. One transfer is one
// command. Output channel (m_axis): one transfer per result; tlast closes the
// run of results belonging to one command.
// Pending entries sit in a chain of cells, earliest deadline at the head.
// A start adds the deadline and registers it; then every cell compares and
// the chain shifts open in the same cycle. Cancel and create also pass
// through the response stage. A tick advances time; then, while the output
// register is free, the head cell is examined and popped one per cycle.
// A fired result is held back one pop so that tlast can be placed on it.
// The output register lets a new command be taken while the last result of
// the previous one still waits. When the receiver stalls, popping and the
// response stage hold until the output register is free.
// Reset (synchronous, active low) empties the chain, sets time to zero and
// marks every timer active; the block is ready as soon as reset is released.
module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIMER_COUNT = sdtq_pkg::TIMER_COUNT_DEF,
    parameter int TIME_BITS   = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [3:0] timer_id, [34:4] interval_ticks, [39:35] zero
    input  logic [sdtq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  logic [sdtq_pkg::CMD_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] fired, [4:1] fired_id, [5] status, [7:6] zero
    output logic [sdtq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int ID_W = sdtq_pkg::ID_W;

    // chain wiring
    logic                 w_v     [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] w_dl    [QUEUE_DEPTH];
    logic [ID_W-1:0]      w_id    [QUEUE_DEPTH];
    logic                 w_found [QUEUE_DEPTH+1];
    sdtq_pkg::t_cell_ctl  w_ctl;

    // control and time
    sdtq_pkg::t_state     r_state, n_state;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIMER_COUNT-1:0] r_cancel, n_cancel;

    // pending insert / response
    logic [TIME_BITS-1:0] r_dl, n_dl;
    logic [ID_W-1:0]      r_id, n_id;
    logic                 r_do_ins, n_do_ins;
    logic                 r_status, n_status;

    // fired result held back until the next one or the end of the run
    logic                 r_pend_v, n_pend_v;
    logic [ID_W-1:0]      r_pend_id, n_pend_id;

    // output register
    logic                 r_out_v;
    logic                 r_out_fired, r_out_status, r_out_last;
    logic [ID_W-1:0]      r_out_id;
    logic                 w_load;
    logic                 w_ld_fired, w_ld_status, w_ld_last;
    logic [ID_W-1:0]      w_ld_id;

    logic                 w_out_free;
    logic                 w_s_acc;
    logic [ID_W-1:0]      w_in_id;
    logic [sdtq_pkg::IVL_W-1:0] w_in_ivl;
    sdtq_pkg::t_cmd       w_cmd;
    logic                 w_id_ok;
    logic                 w_full;
    logic [TIME_BITS-1:0] w_head_diff;
    logic                 w_expired;
    logic                 w_head_cancel;
    logic                 w_head_active;

    assign w_in_id  = i_s_axis_tdata[ID_W-1:0];
    assign w_in_ivl = i_s_axis_tdata[ID_W +: sdtq_pkg::IVL_W];
    assign w_cmd    = sdtq_pkg::t_cmd'(i_s_axis_tuser);
    assign w_id_ok  = int'(w_in_id) < TIMER_COUNT;
    assign w_full   = w_v[QUEUE_DEPTH-1];

    // hold the input closed while reset is asserted
    assign o_s_axis_tready = i_rst_n && (r_state == sdtq_pkg::S_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_v || i_m_axis_tready;

    // Head has expired when its deadline is not after the current time.
    assign w_head_diff = w_dl[0] - r_now;
    assign w_expired   = w_v[0] && ((w_head_diff == '0) || w_head_diff[TIME_BITS-1]);

    always_comb begin
        w_head_cancel = 1'b1;
        for (int t = 0; t < TIMER_COUNT; t++) begin
            if (int'(w_id[0]) == t) begin
                w_head_cancel = r_cancel[t];
            end
        end
    end
    assign w_head_active = !w_head_cancel;

    // chain of cells, head at index 0
    assign w_found[0] = 1'b0;
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                 w_lv, w_rv;
        logic [TIME_BITS-1:0] w_ldl, w_rdl;
        logic [ID_W-1:0]      w_lid, w_rid;
        if (g == 0) begin : g_head
            assign w_lv  = 1'b0;
            assign w_ldl = '0;
            assign w_lid = '0;
        end else begin : g_mid
            assign w_lv  = w_v[g-1];
            assign w_ldl = w_dl[g-1];
            assign w_lid = w_id[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rv  = 1'b0;
            assign w_rdl = '0;
            assign w_rid = '0;
        end else begin : g_body
            assign w_rv  = w_v[g+1];
            assign w_rdl = w_dl[g+1];
            assign w_rid = w_id[g+1];
        end
        sdtq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_new_dl   (r_dl),
            .i_new_id   (r_id),
            .i_found    (w_found[g]),
            .o_found    (w_found[g+1]),
            .i_left_v   (w_lv),
            .i_left_dl  (w_ldl),
            .i_left_id  (w_lid),
            .i_right_v  (w_rv),
            .i_right_dl (w_rdl),
            .i_right_id (w_rid),
            .o_v        (w_v[g]),
            .o_dl       (w_dl[g]),
            .o_id       (w_id[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_cancel    = r_cancel;
        n_dl        = r_dl;
        n_id        = r_id;
        n_do_ins    = r_do_ins;
        n_status    = r_status;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        w_ctl       = '0;
        w_load      = 1'b0;
        w_ld_fired  = 1'b0;
        w_ld_id     = '0;
        w_ld_status = sdtq_pkg::STATUS_OK;
        w_ld_last   = 1'b1;

        case (r_state)
            sdtq_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_do_ins = 1'b0;
                    n_status = sdtq_pkg::STATUS_OK;
                    case (w_cmd)
                        sdtq_pkg::CMD_TICK: begin
                            n_now    = r_now + 1'b1;
                            n_pend_v = 1'b0;
                            n_state  = sdtq_pkg::S_SCAN;
                        end
                        sdtq_pkg::CMD_START: begin
                            n_id     = w_in_id;
                            n_dl     = r_now + TIME_BITS'(w_in_ivl);
                            n_do_ins = w_id_ok && !w_full;
                            n_status = (w_id_ok && w_full) ? sdtq_pkg::STATUS_FULL
                                                           : sdtq_pkg::STATUS_OK;
                            n_state  = sdtq_pkg::S_RESP;
                        end
                        sdtq_pkg::CMD_CANCEL, sdtq_pkg::CMD_CREATE: begin
                            for (int t = 0; t < TIMER_COUNT; t++) begin
                                if (int'(w_in_id) == t) begin
                                    n_cancel[t] = (w_cmd == sdtq_pkg::CMD_CANCEL);
                                end
                            end
                            n_state = sdtq_pkg::S_RESP;
                        end
                        default: begin
                            n_state = sdtq_pkg::S_RESP;
                        end
                    endcase
                end
            end
            sdtq_pkg::S_RESP: begin
                if (w_out_free) begin
                    w_ctl.insert = r_do_ins;
                    w_load       = 1'b1;
                    w_ld_status  = r_status;
                    n_state      = sdtq_pkg::S_IDLE;
                end
            end
            sdtq_pkg::S_SCAN: begin
                if (w_out_free) begin
                    if (w_expired) begin
                        // drop the head; cancelled entries go silently
                        w_ctl.pop = 1'b1;
                        if (w_head_active) begin
                            if (r_pend_v) begin
                                w_load     = 1'b1;
                                w_ld_fired = 1'b1;
                                w_ld_id    = r_pend_id;
                                w_ld_last  = 1'b0;
                            end
                            n_pend_v  = 1'b1;
                            n_pend_id = w_id[0];
                        end
                    end else begin
                        // end of run: flush held result, or report an empty tick
                        w_load     = 1'b1;
                        w_ld_fired = r_pend_v;
                        w_ld_id    = r_pend_v ? r_pend_id : '0;
                        n_pend_v   = 1'b0;
                        n_state    = sdtq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sdtq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdtq_pkg::S_IDLE;
            r_now    <= '0;
            r_cancel <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_do_ins <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_cancel <= n_cancel;
            r_pend_v <= n_pend_v;
            r_do_ins <= n_do_ins;
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
        r_dl      <= n_dl;
        r_id      <= n_id;
        r_status  <= n_status;
        r_pend_id <= n_pend_id;
        if (w_load) begin
            r_out_fired  <= w_ld_fired;
            r_out_id     <= w_ld_id;
            r_out_status <= w_ld_status;
            r_out_last   <= w_ld_last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out_status, r_out_id, r_out_fired};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- design/sdtq_checker.sv -----
`include "sorted_deadline_timer_queue_assert.svh"

// Port-level checks on the timer queue.
module sdtq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [sdtq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    // hold a stalled result unchanged
    `SDTQ_ASSERT_CLK(a_out_hold, (o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)), "stalled result changed")

    // no result straight after reset
    `SDTQ_ASSERT_ALWAYS(a_rst_quiet, (!i_rst_n |=> !o_m_axis_tvalid), "result valid after reset")

    // a command transfer closes the input until it has been worked off
    `SDTQ_ASSERT_CLK(a_one_cmd, (i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready), "second command taken")

    // a dropped start is a single closing result that reports no timer
    `SDTQ_ASSERT_CLK(a_full_last, (o_m_axis_tvalid && o_m_axis_tdata[5] |-> o_m_axis_tlast && !o_m_axis_tdata[0]), "full status on non-final or fired result")

    // a result without a fired timer carries id zero and clean padding
    `SDTQ_ASSERT_CLK(a_idle_id, (o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[4:1] == 4'd0 && o_m_axis_tdata[7:6] == 2'd0), "stray id on empty result")

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);
